>>> rtl/cau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, opcodes and constants of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int DW   = 16;
  localparam int FB   = 8;
  // Width of a sum of two products.
  localparam int PW   = 2 * DW + 1;
  // Low quotient bits kept per part; anything above them only marks overflow.
  localparam int QW   = DW + 1;
  // Divider chain: one quotient bit per cell, from weight 2^(NDIV-1) down to 2^0.
  // The shifted numerator stays below 2^(PW+FB-1).
  localparam int NDIV = PW + FB - 1;
  // Numerator register: the PW bit remainder window on top of NDIV-1 low bits.
  localparam int NW   = PW + NDIV - 1;
  // Square root chain: one result bit per cell.
  localparam int NSQ  = DW;
  localparam int RW   = PW;
  // Top index of the valid pipe, whose last bit drives out_valid.
  localparam int LAT  = NDIV + 3;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_ABS  = 3'd4;
  localparam logic [2:0] OP_CONJ = 3'd5;
  localparam logic [2:0] OP_EQ   = 3'd6;
  localparam logic [2:0] OP_NEQ  = 3'd7;

  typedef struct packed {
    logic [2:0]           func;
    logic signed [DW-1:0] a_re;
    logic signed [DW-1:0] a_im;
    logic signed [DW-1:0] b_re;
    logic signed [DW-1:0] b_im;
  } cau_in_t;

  typedef struct packed {
    logic signed [DW-1:0] res_re;
    logic signed [DW-1:0] res_im;
    logic                 cmp_flag;
    logic                 div_zero;
    logic                 overflow;
  } cau_out_t;

  // State handed from one divider cell to the next.
  typedef struct packed {
    logic [NW-1:0] num_re;
    logic [NW-1:0] num_im;
    logic [QW-1:0] q_re;
    logic [QW-1:0] q_im;
    logic          ovf_re;
    logic          ovf_im;
    logic [PW-1:0] den;
  } cau_div_t;

  // State handed from one square root cell to the next.
  typedef struct packed {
    logic [PW-1:0] rem;
    logic [RW-1:0] root;
  } cau_sq_t;

  // Saturate a signed value of PW+1 bits into the data range.
  function automatic logic [DW:0] sat_s(input logic signed [PW:0] v);
    logic signed [PW:0] mx;
    logic signed [PW:0] mn;
    mx = (PW+1)'((64'sd1 <<< (DW-1)) - 1);
    mn = -mx - (PW+1)'(1);
    if (v > mx) sat_s = {1'b1, 1'b0, {(DW-1){1'b1}}};
    else if (v < mn) sat_s = {1'b1, 1'b1, {(DW-1){1'b0}}};
    else sat_s = {1'b0, v[DW-1:0]};
  endfunction

endpackage

>>> rtl/complex_arithmetic_unit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_core
// Complex ALU in signed Q8.8: add, sub, mul, div, abs, conj, eq, neq.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_data and pulse start; the item transfers when start is high
//   and busy is low. busy is tied low: a new item may enter every cycle.
//   Every item leaves on out_data with out_valid high for exactly one
//   cycle, in order, after the front stages, the divider chain and out_r.
//   The pipe length is set by the divider chain (sized for Q8.8), a row
//   of cells that each resolve one quotient bit for both parts; the first
//   cells also run one integer square root step for the magnitude.
//   Every operation travels the full pipe so results never reorder.
//   The receiver cannot stall; results are always taken.
//   Reset (synchronous, rst_n low) clears the valid pipe; items in flight
//   are dropped.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_core
  import cau_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  cau_in_t  in_data,
  output logic     out_valid,
  output cau_out_t out_data
);

  cau_div_t d_c [NDIV+1];
  cau_sq_t  s_c [NDIV+1];
  cau_out_t fast_c [NDIV+1];
  logic [2:0] op_c [NDIV+1];
  logic nre_c [NDIV+1];
  logic nim_c [NDIV+1];
  logic [LAT:0] vld_r;
  cau_in_t in_r;
  cau_out_t res_nxt, out_r;
  logic [DW:0] t_re, t_im;
  logic [RW-1:0] rt;

  assign busy = 1'b0;

  always_ff @(posedge clk) in_r <= in_data;

  cau_front u_front (
    .clk(clk), .in_r(in_r), .d_out(d_c[0]), .s_out(s_c[0]),
    .fast_out(fast_c[0]), .neg_re(nre_c[0]), .neg_im(nim_c[0]), .op_out(op_c[0])
  );

  // Chain of divider cells; side data rides alongside.
  for (genvar i = 0; i < NDIV; i++) begin : g_cell
    cau_div_cell u_cell (
      .clk(clk), .sq_en(i < NSQ), .idx(6'(i)), .d_in(d_c[i]), .s_in(s_c[i]),
      .d_out(d_c[i+1]), .s_out(s_c[i+1])
    );
    always_ff @(posedge clk) begin
      fast_c[i+1] <= fast_c[i];
      op_c[i+1]   <= op_c[i];
      nre_c[i+1]  <= nre_c[i];
      nim_c[i+1]  <= nim_c[i];
    end
  end

  // Final selection and saturation; an oversized quotient saturates by sign.
  always_comb begin
    res_nxt = fast_c[NDIV];
    if (d_c[NDIV].ovf_re)
      t_re = {1'b1, nre_c[NDIV], {(DW-1){!nre_c[NDIV]}}};
    else
      t_re = sat_s(nre_c[NDIV] ? -(PW+1)'(d_c[NDIV].q_re) : (PW+1)'(d_c[NDIV].q_re));
    if (d_c[NDIV].ovf_im)
      t_im = {1'b1, nim_c[NDIV], {(DW-1){!nim_c[NDIV]}}};
    else
      t_im = sat_s(nim_c[NDIV] ? -(PW+1)'(d_c[NDIV].q_im) : (PW+1)'(d_c[NDIV].q_im));
    rt   = s_c[NDIV].root;
    case (op_c[NDIV])
      OP_DIV: begin
        if (!fast_c[NDIV].div_zero) begin
          res_nxt.res_re   = t_re[DW-1:0];
          res_nxt.res_im   = t_im[DW-1:0];
          res_nxt.overflow = t_re[DW] | t_im[DW];
        end
      end
      OP_ABS: begin
        res_nxt.res_im = '0;
        if (|rt[RW-1:DW-1]) begin
          res_nxt.res_re   = {1'b0, {(DW-1){1'b1}}};
          res_nxt.overflow = 1'b1;
        end else begin
          res_nxt.res_re   = rt[DW-1:0];
          res_nxt.overflow = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_r <= res_nxt;
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[LAT-1:0], start};
  end

  assign out_valid = vld_r[LAT];
  assign out_data  = out_r;

endmodule

>>> rtl/cau_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_div_cell
// One restoring division step for both result parts, plus one square root
// step when the cell index is inside the root chain.
// ----------------------------------------------------------------------------
module cau_div_cell
  import cau_pkg::*;
(
  input  logic     clk,
  input  logic     sq_en,
  input  logic [5:0] idx,
  input  cau_div_t d_in,
  input  cau_sq_t  s_in,
  output cau_div_t d_out,
  output cau_sq_t  s_out
);

  logic [PW:0]  trial_re, trial_im;
  logic [NW-1:0] sh_re, sh_im;
  cau_div_t     d_nxt;
  cau_sq_t      s_nxt;
  logic [PW-1:0] cand;
  logic [PW-1:0] bitv;

  // The partial remainder is the top PW bits of the numerator register.
  // A quotient bit shifted out at the top marks an oversized quotient.
  always_comb begin
    d_nxt    = d_in;
    trial_re = {1'b0, d_in.num_re[NW-1 -: PW]} - {1'b0, d_in.den};
    trial_im = {1'b0, d_in.num_im[NW-1 -: PW]} - {1'b0, d_in.den};
    sh_re    = d_in.num_re;
    sh_im    = d_in.num_im;
    if (!trial_re[PW]) sh_re[NW-1 -: PW] = trial_re[PW-1:0];
    if (!trial_im[PW]) sh_im[NW-1 -: PW] = trial_im[PW-1:0];
    d_nxt.num_re = {sh_re[NW-2:0], 1'b0};
    d_nxt.num_im = {sh_im[NW-2:0], 1'b0};
    d_nxt.q_re   = {d_in.q_re[QW-2:0], ~trial_re[PW]};
    d_nxt.q_im   = {d_in.q_im[QW-2:0], ~trial_im[PW]};
    d_nxt.ovf_re = d_in.ovf_re | d_in.q_re[QW-1];
    d_nxt.ovf_im = d_in.ovf_im | d_in.q_im[QW-1];
  end

  // Square root step: test bit 4^(NSQ-1-idx) against the remainder.
  always_comb begin
    s_nxt = s_in;
    bitv  = PW'(1) << (2 * (NSQ - 1 - idx));
    cand  = s_in.root + bitv;
    if (sq_en) begin
      if (s_in.rem >= cand) begin
        s_nxt.rem  = s_in.rem - cand;
        s_nxt.root = (s_in.root >> 1) + bitv;
      end else begin
        s_nxt.root = s_in.root >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    d_out <= d_nxt;
    s_out <= s_nxt;
  end

endmodule

>>> rtl/cau_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_front
// Operand products and sums, the short operations, and the numerator and
// denominator setup for the divider chain.
// ----------------------------------------------------------------------------
module cau_front
  import cau_pkg::*;
(
  input  logic     clk,
  input  cau_in_t  in_r,
  output cau_div_t d_out,
  output cau_sq_t  s_out,
  output cau_out_t fast_out,
  output logic     neg_re,
  output logic     neg_im,
  output logic [2:0] op_out
);

  logic signed [2*DW-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r, p_bb_r, p_cc_r, p_aa_r, p_dd_r;
  cau_in_t in_d_r;
  logic signed [PW:0] mre, mim, dre, dim, s_re, s_im;
  logic [DW:0] t_re, t_im;
  logic [PW-1:0] den, nre, nim;
  cau_out_t f;

  // Stage one: all products registered.
  always_ff @(posedge clk) begin
    p_rr_r <= in_r.a_re * in_r.b_re;
    p_ii_r <= in_r.a_im * in_r.b_im;
    p_ri_r <= in_r.a_re * in_r.b_im;
    p_ir_r <= in_r.a_im * in_r.b_re;
    p_bb_r <= in_r.b_re * in_r.b_re;
    p_cc_r <= in_r.b_im * in_r.b_im;
    p_aa_r <= in_r.a_re * in_r.a_re;
    p_dd_r <= in_r.a_im * in_r.a_im;
    in_d_r <= in_r;
  end

  // Stage two: sums, short results and divider setup.
  always_comb begin
    mre = (PW+1)'(p_rr_r) - (PW+1)'(p_ii_r);
    mim = (PW+1)'(p_ri_r) + (PW+1)'(p_ir_r);
    dre = (PW+1)'(p_rr_r) + (PW+1)'(p_ii_r);
    dim = (PW+1)'(p_ir_r) - (PW+1)'(p_ri_r);
    den = PW'(unsigned'(p_bb_r)) + PW'(unsigned'(p_cc_r));
    nre = dre[PW] ? PW'(-dre) : PW'(dre);
    nim = dim[PW] ? PW'(-dim) : PW'(dim);
    f   = '0;
    s_re = '0;
    s_im = '0;
    case (in_d_r.func)
      OP_ADD: begin
        s_re = (PW+1)'(in_d_r.a_re) + (PW+1)'(in_d_r.b_re);
        s_im = (PW+1)'(in_d_r.a_im) + (PW+1)'(in_d_r.b_im);
      end
      OP_SUB: begin
        s_re = (PW+1)'(in_d_r.a_re) - (PW+1)'(in_d_r.b_re);
        s_im = (PW+1)'(in_d_r.a_im) - (PW+1)'(in_d_r.b_im);
      end
      OP_MUL: begin
        s_re = mre >>> FB;
        s_im = mim >>> FB;
      end
      OP_CONJ: begin
        s_re = (PW+1)'(in_d_r.a_re);
        s_im = -(PW+1)'(in_d_r.a_im);
      end
      default: begin
      end
    endcase
    t_re = sat_s(s_re);
    t_im = sat_s(s_im);
    f.res_re   = t_re[DW-1:0];
    f.res_im   = t_im[DW-1:0];
    f.overflow = t_re[DW] | t_im[DW];
    f.div_zero = (in_d_r.func == OP_DIV) && (den == '0);
    if (in_d_r.func == OP_EQ)
      f.cmp_flag = (in_d_r.a_re == in_d_r.b_re) && (in_d_r.a_im == in_d_r.b_im);
    if (in_d_r.func == OP_NEQ)
      f.cmp_flag = !((in_d_r.a_re == in_d_r.b_re) && (in_d_r.a_im == in_d_r.b_im));
  end

  // The numerator enters zero extended, so the first window holds its top bit.
  always_ff @(posedge clk) begin
    fast_out     <= f;
    neg_re       <= dre[PW];
    neg_im       <= dim[PW];
    op_out       <= in_d_r.func;
    d_out.num_re <= NW'({nre, FB'(0)});
    d_out.num_im <= NW'({nim, FB'(0)});
    d_out.q_re   <= '0;
    d_out.q_im   <= '0;
    d_out.ovf_re <= 1'b0;
    d_out.ovf_im <= 1'b0;
    d_out.den    <= (den == '0) ? PW'(1) : den;
    s_out.rem    <= PW'(unsigned'(p_aa_r)) + PW'(unsigned'(p_dd_r));
    s_out.root   <= '0;
  end

endmodule

>>> rtl/cau_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_checker
// Port level checks of the complex arithmetic unit.
// ----------------------------------------------------------------------------
module cau_checker
  import cau_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input cau_out_t out_data
);

  // A result never reports both a zero divisor and an overflow.
  a_dz_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.div_zero && out_data.overflow)) else $error("dz and ovf");

  // A zero divisor result is zero.
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.div_zero |-> out_data.res_re == '0 && out_data.res_im == '0)
    else $error("dz nonzero");

  // The unit always takes a new item.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy) else $error("busy");

  // A result with the comparison flag set carries zero parts.
  a_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.cmp_flag |-> out_data.res_re == '0 && out_data.res_im == '0)
    else $error("cmp parts");

endmodule

bind complex_arithmetic_unit_core cau_checker u_cau_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_data(out_data)
);

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Drives random and corner-case complex operands through every opcode and
// compares each result against a fixed-point predictor, in order.
// ----------------------------------------------------------------------------
module testbench;
  import cau_pkg::*;

  // Tracks the expected results and compares them against the block output.
  class cau_scoreboard;
    cau_out_t pending_q[$];
    int errors = 0;

    // Saturate a signed value to the data range; floor shift is done by caller.
    static function automatic logic signed [DW-1:0] clamp(
        input logic signed [127:0] v, inout logic ovf);
      logic signed [127:0] mx;
      mx = (128'sd1 <<< (DW-1)) - 1;
      if (v > mx) begin
        ovf = 1'b1;
        return mx[DW-1:0];
      end
      if (v < -mx - 1) begin
        ovf = 1'b1;
        return ~mx[DW-1:0];
      end
      return v[DW-1:0];
    endfunction

    // Divide one part: truncate toward zero, with huge quotients clamped.
    static function automatic logic signed [DW-1:0] div_part(
        input logic signed [127:0] num, input logic signed [127:0] den,
        inout logic ovf);
      logic signed [127:0] mag;
      logic signed [127:0] q;
      mag = (num < 0) ? -num : num;
      q = (mag <<< FB) / den;
      if (num < 0) q = -q;
      return clamp(q, ovf);
    endfunction

    static function automatic cau_out_t compute(input cau_in_t x);
      cau_out_t r;
      logic signed [127:0] ar, ai, br, bi, den, m, s;
      logic ovf;
      ar = x.a_re; ai = x.a_im; br = x.b_re; bi = x.b_im;
      r = '0;
      ovf = 1'b0;
      case (x.func)
        OP_ADD: begin
          r.res_re = clamp(ar + br, ovf);
          r.res_im = clamp(ai + bi, ovf);
        end
        OP_SUB: begin
          r.res_re = clamp(ar - br, ovf);
          r.res_im = clamp(ai - bi, ovf);
        end
        OP_MUL: begin
          r.res_re = clamp((ar * br - ai * bi) >>> FB, ovf);
          r.res_im = clamp((ar * bi + ai * br) >>> FB, ovf);
        end
        OP_DIV: begin
          den = br * br + bi * bi;
          if (den == 0) begin
            r.div_zero = 1'b1;
          end else begin
            r.res_re = div_part(ar * br + ai * bi, den, ovf);
            r.res_im = div_part(ai * br - ar * bi, den, ovf);
          end
        end
        OP_ABS: begin
          m = ar * ar + ai * ai;
          s = 0;
          for (int b = 17; b >= 0; b--) begin
            if ((s + (128'sd1 <<< b)) * (s + (128'sd1 <<< b)) <= m)
              s = s + (128'sd1 <<< b);
          end
          r.res_re = clamp(s, ovf);
        end
        OP_CONJ: begin
          r.res_re = x.a_re;
          r.res_im = clamp(-ai, ovf);
        end
        OP_EQ:  r.cmp_flag = (x.a_re == x.b_re) && (x.a_im == x.b_im);
        default: r.cmp_flag = !((x.a_re == x.b_re) && (x.a_im == x.b_im));
      endcase
      r.overflow = ovf;
      return r;
    endfunction

    function void note_input(input cau_in_t x);
      pending_q.push_back(compute(x));
    endfunction

    function void check_result(input cau_out_t got);
      cau_out_t want;
      if (pending_q.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.res_re !== want.res_re) begin
        $error("res_re expected %h actual %h", want.res_re, got.res_re); errors++;
      end
      if (got.res_im !== want.res_im) begin
        $error("res_im expected %h actual %h", want.res_im, got.res_im); errors++;
      end
      if (got.cmp_flag !== want.cmp_flag) begin
        $error("cmp_flag expected %b actual %b", want.cmp_flag, got.cmp_flag);
        errors++;
      end
      if (got.div_zero !== want.div_zero) begin
        $error("div_zero expected %b actual %b", want.div_zero, got.div_zero);
        errors++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow expected %b actual %b", want.overflow, got.overflow);
        errors++;
      end
    endfunction
  endclass

  localparam int WATCHDOG = 5000;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  cau_in_t  in_data;
  logic     out_valid;
  cau_out_t out_data;

  cau_scoreboard board;
  int idle_cycles = 0;
  bit timed_out = 0;

  complex_arithmetic_unit_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Check results and note transfers at each rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) board.note_input(in_data);
      if (out_valid) board.check_result(out_data);
      if ((start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) timed_out = 1;
    end
  end

  // Pick an operand value, biased toward the range edges.
  function automatic logic [DW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(0, 1023)) - 512);
      default: return 16'($urandom());
    endcase
  endfunction

  // Present one item and hold it until it transfers.
  task automatic send_item(input cau_in_t x, input bit allow_gap);
    while (allow_gap && $urandom_range(0, 99) < 21) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= x;
    @(posedge clk);
    while (busy && !timed_out) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(input int count, input bit allow_gap);
    cau_in_t x;
    for (int n = 0; n < count; n++) begin
      x.func = 3'($urandom_range(0, 7));
      x.a_re = pick_value();
      x.a_im = pick_value();
      if ($urandom_range(0, 5) == 0) begin
        x.b_re = x.a_re;
        x.b_im = x.a_im;
      end else if (x.func == OP_DIV && $urandom_range(0, 7) == 0) begin
        x.b_re = '0;
        x.b_im = '0;
      end else begin
        x.b_re = pick_value();
        x.b_im = pick_value();
      end
      send_item(x, allow_gap);
    end
  endtask

  // Main sequence: reset, directed corners, random items, drain.
  initial begin
    cau_in_t x;
    int drain;
    board   = new();
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed corners: each opcode at the extremes, zero divisor, compares.
    for (int op = 0; op < 8; op++) begin
      x = '{func: 3'(op), a_re: 16'h7fff, a_im: 16'h8000,
            b_re: 16'h7fff, b_im: 16'h7fff};
      send_item(x, 1'b0);
      x = '{func: 3'(op), a_re: 16'h8000, a_im: 16'h8000,
            b_re: 16'h8000, b_im: 16'h8000};
      send_item(x, 1'b0);
    end
    x = '{func: OP_DIV, a_re: 16'h0100, a_im: 16'h0200, b_re: 16'h0, b_im: 16'h0};
    send_item(x, 1'b0);
    x = '{func: OP_DIV, a_re: 16'h7fff, a_im: 16'h7fff, b_re: 16'h0001, b_im: 16'h0};
    send_item(x, 1'b0);
    x = '{func: OP_EQ, a_re: 16'h1234, a_im: 16'h5678, b_re: 16'h1234, b_im: 16'h5678};
    send_item(x, 1'b0);
    x = '{func: OP_NEQ, a_re: 16'h1234, a_im: 16'h5678, b_re: 16'h1234, b_im: 16'h5679};
    send_item(x, 1'b0);
    x = '{func: OP_ABS, a_re: 16'h0, a_im: 16'h0, b_re: 16'hffff, b_im: 16'hffff};
    send_item(x, 1'b0);

    // Random items: a burst without gaps, then with random gaps.
    send_random(300, 1'b0);
    send_random(1200, 1'b1);
    start <= 1'b0;

    drain = 0;
    while (board.pending_q.size() != 0 && !timed_out) @(posedge clk);
    while (drain < LAT + 10 && !timed_out) begin
      @(posedge clk);
      drain++;
    end
    if (timed_out) begin
      $display("TEST FAILED");
    end else if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
